// ===== hw/rtl/ll2m_pkg.sv =====
// shared types, constants and fixed-point helpers for the lat/lon to local meters block
`default_nettype none

package ll2m_pkg;

  localparam int CW      = 44;
  localparam int SQW     = 62;
  localparam int SQ_STEPS = 31;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic [40:0]          q40_t;
  typedef logic [30:0]          hdeg_t;

  typedef enum logic {
    REG_ORIGIN_LAT = 1'b0,
    REG_ORIGIN_LON = 1'b1
  } cfg_reg_t;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam q40_t        ONE_Q40     = 41'h100_0000_0000;
  localparam q40_t        HALF_PI_Q40 = 41'(PI_Q60 >> 21);
  localparam cw_t         GAIN_Q40    = 44'sd667681663043;
  localparam logic [31:0] TWO_R_Q8    = 32'd3265606144;
  localparam logic [32:0] DEG180_Q24  = 33'd3019898880;
  localparam logic [32:0] DEG360_Q24  = 33'd6039797760;
  localparam logic [29:0] DEG90_Q23   = 30'd754974720;
  localparam logic [32:0] D2R         = 33'((PI_Q60 / 64'd180) >> 22);

  // atan(2^-i) in q40, series evaluated at elaboration
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned n;
    sum = '0;
    if (i == 0) begin
      return ((PI_Q60 >> 2) + 64'd524288) >> 20;
    end
    if (i >= 60) begin
      return '0;
    end
    p = 64'd1 << (60 - i);
    for (n = 0; n < 64; n++) begin
      if (p != '0) begin
        t = p / 64'(2 * n + 1);
        if (n[0]) sum = sum - t;
        else sum = sum + t;
        p = (2 * i < 64) ? (p >> (2 * i)) : '0;
      end
    end
    return (sum + 64'd524288) >> 20;
  endfunction

  // difference can exceed a half turn but stays under a full turn
  function automatic hdeg_t fold_half(input logic [32:0] d);
    logic [32:0] h;
    h = d;
    if (h >= DEG360_Q24) h = h - DEG360_Q24;
    else if (h >= DEG180_Q24) h = h - DEG180_Q24;
    if (h > (DEG180_Q24 >> 1)) h = DEG180_Q24 - h;
    return h[30:0];
  endfunction

  function automatic cw_t deg_to_rad(input hdeg_t h);
    logic [63:0] p;
    p = 64'(h) * 64'(D2R);
    return cw_t'((p + 64'd2097152) >> 22);
  endfunction

  function automatic q40_t clamp_unit(input cw_t y);
    if (y < 0) return '0;
    if (y > cw_t'(ONE_Q40)) return ONE_Q40;
    return y[40:0];
  endfunction

  function automatic q40_t clamp_ang(input cw_t z);
    if (z < 0) return '0;
    if (z > cw_t'(HALF_PI_Q40)) return HALF_PI_Q40;
    return z[40:0];
  endfunction

  // finish a q40 product from its two partial products, clamped to one
  function automatic q40_t mul_fin(input logic [61:0] hi, input logic [60:0] lo);
    logic [42:0] s;
    s = 43'(hi >> 20) + 43'(lo >> 40);
    if (s > 43'(ONE_Q40)) return ONE_Q40;
    return s[40:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ll2m_rot.sv =====
// rotation-mode cordic pipeline, one stage per register, gives the sine of z
`default_nettype none

module ll2m_rot import ll2m_pkg::*; #(
  parameter int STAGES = 24
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cw_t  z_in,
  output cw_t       y_out
);

  cw_t x_r [STAGES];
  cw_t y_r [STAGES];
  cw_t z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam cw_t ATAN = cw_t'(atan_entry(i));
    cw_t xi;
    cw_t yi;
    cw_t zi;
    if (i == 0) begin : g_first
      assign xi = GAIN_Q40;
      assign yi = '0;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN;
        end
      end
    end
  end

  assign y_out = y_r[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ll2m_vec.sv =====
// vectoring-mode cordic pipeline, gives atan2(y, x) in q40 radians
`default_nettype none

module ll2m_vec import ll2m_pkg::*; #(
  parameter int STAGES = 24
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cw_t  x_in,
  input  wire cw_t  y_in,
  output cw_t       z_out
);

  cw_t x_r [STAGES];
  cw_t y_r [STAGES];
  cw_t z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam cw_t ATAN = cw_t'(atan_entry(i));
    cw_t  xi;
    cw_t  yi;
    cw_t  zi;
    logic pos;
    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    assign pos = !yi[CW-1] && (yi != '0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN;
        end
      end
    end
  end

  assign z_out = z_r[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ll2m_sqrt.sv =====
// digit-by-digit integer square root, one result bit per pipeline stage
`default_nettype none

module ll2m_sqrt import ll2m_pkg::*; (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [SQW-1:0] v_in,
  output logic [30:0]         root
);

  logic [SQW-1:0] v_r   [SQ_STEPS];
  logic [SQW-1:0] res_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQW-1:0] vi;
    logic [SQW-1:0] ri;
    logic [SQW-1:0] t;
    if (k == 0) begin : g_first
      assign vi = v_in;
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign ri = res_r[k-1];
    end
    assign t = ri + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= t) begin
          v_r[k]   <= vi - t;
          res_r[k] <= (ri >> 1) + BIT;
        end else begin
          v_r[k]   <= vi;
          res_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign root = res_r[SQ_STEPS-1][30:0];

endmodule

`default_nettype wire

// ===== hw/rtl/latlon_to_local_meters.sv =====
// top level: east and north offset of a point from the origin, haversine in fixed point
// throughput: one item per cycle while the output is not stalled;
// depth is set by the cordic chains and two 31-step roots
// a stalled output holds the whole pipeline, nothing is dropped
// reset (rst_n low, synchronous) clears the origin registers and all valid bits
`default_nettype none

module latlon_to_local_meters import ll2m_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // point_lat[30:0], point_lon[62:31]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // east_meters[32:0], north_meters[65:33]
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int LAT = 2 * CORDIC_STAGES + 73;
  localparam int ND  = 2 * CORDIC_STAGES + 68;
  localparam int SD  = 33;

  logic               adv;
  logic [LAT-1:0]     vld_r;
  logic signed [30:0] origin_lat_r;
  logic signed [31:0] origin_lon_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lat_r <= '0;
      origin_lon_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_LAT: origin_lat_r <= cfg_data[30:0];
        REG_ORIGIN_LON: origin_lon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv       = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // stage 1: differences and cosine arguments
  logic signed [30:0] lat;
  logic signed [31:0] lon;
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic [30:0]        alat;
  logic [30:0]        alat0;
  logic [30:0]        slat;
  logic [30:0]        slat0;
  logic [31:0]        s1_dlat_r;
  logic [32:0]        s1_dlon_r;
  hdeg_t              s1_carg0_r;
  hdeg_t              s1_carg1_r;

  always_comb begin
    lat   = in_tdata[30:0];
    lon   = in_tdata[62:31];
    dlat  = {lat[30], lat} - {origin_lat_r[30], origin_lat_r};
    dlon  = {lon[31], lon} - {origin_lon_r[31], origin_lon_r};
    alat  = lat[30] ? 31'(-lat) : 31'(lat);
    alat0 = origin_lat_r[30] ? 31'(-origin_lat_r) : 31'(origin_lat_r);
    slat  = (alat > 31'(DEG90_Q23)) ? 31'(DEG90_Q23) : alat;
    slat0 = (alat0 > 31'(DEG90_Q23)) ? 31'(DEG90_Q23) : alat0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dlat_r  <= dlat[31] ? 32'(-dlat) : 32'(dlat);
      s1_dlon_r  <= dlon[32] ? 33'(-dlon) : 33'(dlon);
      s1_carg0_r <= 31'((31'(DEG90_Q23) - slat0) << 1);
      s1_carg1_r <= 31'((31'(DEG90_Q23) - slat) << 1);
    end
  end

  // stage 2: fold half angles
  hdeg_t s2_hn_r;
  hdeg_t s2_he_r;
  hdeg_t s2_carg0_r;
  hdeg_t s2_carg1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hn_r    <= fold_half({1'b0, s1_dlat_r});
      s2_he_r    <= fold_half(s1_dlon_r);
      s2_carg0_r <= s1_carg0_r;
      s2_carg1_r <= s1_carg1_r;
    end
  end

  // stage 3: degrees to radians
  cw_t s3_north_r;
  cw_t s3_zs_r;
  cw_t s3_z0_r;
  cw_t s3_z1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_north_r <= deg_to_rad(s2_hn_r);
      s3_zs_r    <= deg_to_rad(s2_he_r);
      s3_z0_r    <= deg_to_rad(s2_carg0_r);
      s3_z1_r    <= deg_to_rad(s2_carg1_r);
    end
  end

  // sines and cosines
  cw_t y_s;
  cw_t y_c0;
  cw_t y_c1;

  ll2m_rot #(.STAGES(CORDIC_STAGES)) u_rot_s (
    .clk(clk), .en(adv), .z_in(s3_zs_r), .y_out(y_s)
  );
  ll2m_rot #(.STAGES(CORDIC_STAGES)) u_rot_c0 (
    .clk(clk), .en(adv), .z_in(s3_z0_r), .y_out(y_c0)
  );
  ll2m_rot #(.STAGES(CORDIC_STAGES)) u_rot_c1 (
    .clk(clk), .en(adv), .z_in(s3_z1_r), .y_out(y_c1)
  );

  // cos(lat0) * cos(lat), then root
  q40_t        c0;
  q40_t        c1;
  logic [61:0] m1_hi_r;
  logic [60:0] m1_lo_r;
  q40_t        m2_x_r;
  q40_t        sdl_r [SD];
  logic [30:0] root1;

  assign c0 = clamp_unit(y_c0);
  assign c1 = clamp_unit(y_c1);

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_hi_r  <= 62'(c0) * 62'(c1[40:20]);
      m1_lo_r  <= 61'(c0) * 61'(c1[19:0]);
      m2_x_r   <= mul_fin(m1_hi_r, m1_lo_r);
      sdl_r[0] <= clamp_unit(y_s);
      for (int k = 1; k < SD; k++) sdl_r[k] <= sdl_r[k-1];
    end
  end

  ll2m_sqrt u_sqrt_r (
    .clk(clk), .en(adv), .v_in(SQW'({m2_x_r, 20'd0})), .root(root1)
  );

  // u = sin * root, then sqrt(1 - u^2)
  q40_t        r;
  logic [61:0] m3_hi_r;
  logic [60:0] m3_lo_r;
  q40_t        u_r;
  logic [61:0] m5_hi_r;
  logic [60:0] m5_lo_r;
  q40_t        m6_x_r;
  q40_t        udl_r [SD];
  logic [30:0] root2;
  q40_t        w;

  assign r = {root1, 10'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_hi_r  <= 62'(sdl_r[SD-1]) * 62'(r[40:20]);
      m3_lo_r  <= 61'(sdl_r[SD-1]) * 61'(r[19:0]);
      u_r      <= mul_fin(m3_hi_r, m3_lo_r);
      m5_hi_r  <= 62'(u_r) * 62'(u_r[40:20]);
      m5_lo_r  <= 61'(u_r) * 61'(u_r[19:0]);
      m6_x_r   <= ONE_Q40 - mul_fin(m5_hi_r, m5_lo_r);
      udl_r[0] <= u_r;
      for (int k = 1; k < SD; k++) udl_r[k] <= udl_r[k-1];
    end
  end

  ll2m_sqrt u_sqrt_w (
    .clk(clk), .en(adv), .v_in(SQW'({m6_x_r, 20'd0})), .root(root2)
  );

  assign w = {root2, 10'd0};

  // asin via atan2(u, w)
  cw_t z_east;

  ll2m_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .en(adv), .x_in(cw_t'(w)), .y_in(cw_t'(udl_r[SD-1])), .z_out(z_east)
  );

  // north angle rides alongside
  cw_t ndl_r [ND];

  always_ff @(posedge clk) begin
    if (adv) begin
      ndl_r[0] <= s3_north_r;
      for (int k = 1; k < ND; k++) ndl_r[k] <= ndl_r[k-1];
    end
  end

  // angle to meters
  q40_t        ea;
  q40_t        na;
  logic [52:0] e1_ehi_r;
  logic [51:0] e1_elo_r;
  logic [52:0] e1_nhi_r;
  logic [51:0] e1_nlo_r;
  logic [53:0] esum;
  logic [53:0] nsum;
  logic [32:0] east_r;
  logic [32:0] north_r;

  assign ea = clamp_ang(z_east);
  assign na = clamp_ang(ndl_r[ND-1]);

  assign esum = 54'(e1_ehi_r) + 54'(e1_elo_r >> 20) + 54'd524288;
  assign nsum = 54'(e1_nhi_r) + 54'(e1_nlo_r >> 20) + 54'd524288;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_ehi_r <= 53'(ea[40:20]) * 53'(TWO_R_Q8);
      e1_elo_r <= 52'(ea[19:0]) * 52'(TWO_R_Q8);
      e1_nhi_r <= 53'(na[40:20]) * 53'(TWO_R_Q8);
      e1_nlo_r <= 52'(na[19:0]) * 52'(TWO_R_Q8);
      east_r   <= esum[52:20];
      north_r  <= nsum[52:20];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {6'd0, north_r, east_r};

`ifndef ASSERT_OFF
  a_east_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:0] <= 33'd5129602560))
    else $error("east offset beyond half circumference");

  a_north_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:33] <= 33'd5129602560))
    else $error("north offset beyond half circumference");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

// ===== verif/ll2m_checker.sv =====
// checker: watches the point and offset channels, predicts each offset and compares
`timescale 1ns / 100ps
`default_nettype none

module ll2m_checker import ll2m_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               checked
);

  localparam int STAGES = 24;
  localparam longint unsigned PI60 = 64'h3243F6A8885A308D;
  localparam longint ONE = 64'sd1 << 40;
  localparam longint QUARTER_TURN = longint'(PI60 >> 21);
  localparam longint GAIN = 64'sd667681663043;
  localparam longint unsigned DIAM_Q8 = 64'd3265606144;
  localparam longint unsigned HALF_TURN_Q24 = 64'd3019898880;
  localparam longint unsigned RIGHT_Q23 = 64'd754974720;

  typedef struct packed {
    logic [32:0] east;
    logic [32:0] north;
  } offset_t;

  longint arctan_q40 [STAGES];
  logic [30:0] lat_origin;
  logic [31:0] lon_origin;
  offset_t offsets_due [$];

  function automatic longint arctan_series(int k);
    longint unsigned p, acc, t;
    int n;
    acc = 0;
    n = 0;
    if (k == 0) return longint'(((PI60 >> 2) + 64'd524288) >> 20);
    p = 64'd1 << (60 - k);
    while (p != 0) begin
      t = p / longint'(2 * n + 1);
      if (n % 2 == 1) acc = acc - t;
      else acc = acc + t;
      n++;
      p = (2 * k < 64) ? (p >> (2 * k)) : 64'd0;
    end
    return longint'((acc + 64'd524288) >> 20);
  endfunction

  function automatic longint unsigned half_fold(longint unsigned d);
    longint unsigned h;
    h = d % HALF_TURN_Q24;
    if (h > HALF_TURN_Q24 / 2) h = HALF_TURN_Q24 - h;
    return h;
  endfunction

  function automatic longint radians(longint unsigned h);
    longint unsigned k;
    k = (PI60 / 180) >> 22;
    return longint'((h * k + 64'd2097152) >> 22);
  endfunction

  function automatic longint unsigned prod_q40(longint unsigned a, longint unsigned b);
    return ((a * (b >> 20)) >> 20) + ((a * (b & 64'hFFFFF)) >> 40);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned root_q40(longint unsigned x);
    if (x > ONE) x = ONE;
    return int_root(x << 20) << 10;
  endfunction

  function automatic longint unsigned sine_q40(longint unsigned h);
    longint x, y, z, dx, dy;
    z = radians(h);
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q40[i];
      end else begin
        x += dx; y -= dy; z += arctan_q40[i];
      end
    end
    if (y < 0) return 0;
    if (y > ONE) return ONE;
    return y;
  endfunction

  function automatic longint unsigned cosine_lat(longint lat);
    longint unsigned a;
    a = (lat < 0) ? -lat : lat;
    if (a > RIGHT_Q23) a = RIGHT_Q23;
    return sine_q40((RIGHT_Q23 - a) << 1);
  endfunction

  function automatic longint arcsine_angle(longint unsigned u, longint unsigned w);
    longint x, y, z, dx, dy;
    x = w;
    y = u;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q40[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q40[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_TURN) z = QUARTER_TURN;
    return z;
  endfunction

  function automatic logic [32:0] arc_meters(longint ang);
    longint unsigned a;
    a = (ang < 0) ? 0 : ((ang > QUARTER_TURN) ? QUARTER_TURN : ang);
    return 33'(((a >> 20) * DIAM_Q8 + (((a & 64'hFFFFF) * DIAM_Q8) >> 20) + 64'd524288)
               >> 20);
  endfunction

  function automatic offset_t predict_offset(logic [30:0] p_lat, logic [31:0] p_lon);
    longint lat0, lon0, lat, lon, dlat, dlon;
    longint unsigned hn, he, c0, c1, s, r, u, w;
    offset_t o;
    lat0 = longint'(signed'(lat_origin));
    lon0 = longint'(signed'(lon_origin));
    lat = longint'(signed'(p_lat));
    lon = longint'(signed'(p_lon));
    dlat = lat - lat0;
    dlon = lon - lon0;
    hn = half_fold(dlat < 0 ? -dlat : dlat);
    he = half_fold(dlon < 0 ? -dlon : dlon);
    c0 = cosine_lat(lat0);
    c1 = cosine_lat(lat);
    s = sine_q40(he);
    r = root_q40(prod_q40(c0, c1));
    u = prod_q40(s, r);
    if (u > ONE) u = ONE;
    w = root_q40(ONE - prod_q40(u, u));
    o.east = arc_meters(arcsine_angle(u, w));
    o.north = arc_meters(radians(hn));
    return o;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    lat_origin = '0;
    lon_origin = '0;
    for (int i = 0; i < STAGES; i++) arctan_q40[i] = arctan_series(i);
  end

  always @(posedge clk) begin
    offset_t want;
    if (!rst_n) begin
      lat_origin = '0;
      lon_origin = '0;
    end else begin
      if (in_tvalid && in_tready)
        offsets_due.push_back(predict_offset(in_tdata[30:0], in_tdata[62:31]));
      if (out_tvalid && out_tready) begin
        if (offsets_due.size() == 0) begin
          report("unexpected item, east", 0, out_tdata[32:0]);
        end else begin
          want = offsets_due.pop_front();
          checked++;
          if (out_tdata[32:0] != want.east) report("east", want.east, out_tdata[32:0]);
          if (out_tdata[65:33] != want.north) report("north", want.north, out_tdata[65:33]);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_ORIGIN_LAT) lat_origin = cfg_data[30:0];
        else lon_origin = cfg_data;
      end
    end
    pending = offsets_due.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_latlon_to_local_meters.sv =====
// testbench top: drives points and origin writes through idle phases and gives the verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_latlon_to_local_meters import ll2m_pkg::*; ();

  localparam longint DEG90 = 64'sd754974720;
  localparam longint DEG180 = 64'sd1509949440;
  localparam int LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_ORIGIN_LAT;
  logic [31:0] cfg_data = '0;

  int errors, pending, checked;
  int cycles = 0;
  int idle_mode = 0;
  int sent = 0;
  logic point_taken = 1'b0;

  always #5 clk = ~clk;

  latlon_to_local_meters dut (.*);

  ll2m_checker u_checker (.*);

  always @(posedge clk) begin
    point_taken <= in_tvalid & in_tready;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("latlon_to_local_meters: mismatch");
      $finish;
    end
  end

  // receiver stalls: mode 2 stalls 71 in 100, mode 3 stalls 30 in 100
  always @(negedge clk) begin
    if (idle_mode == 2) out_tready <= ($urandom % 100) >= 71;
    else if (idle_mode == 3) out_tready <= ($urandom % 100) >= 30;
    else out_tready <= 1'b1;
  end

  task automatic send_point(longint lat, longint lon);
    int gap;
    gap = (idle_mode == 1) ? 71 : ((idle_mode == 3) ? 30 : 0);
    while (($urandom % 100) < gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, lon[31:0], lat[30:0]};
    do @(negedge clk); while (!point_taken);
    sent++;
  endtask

  task automatic set_origin(longint lat, longint lon);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (130) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ORIGIN_LAT;
    cfg_data <= 32'(lat);
    @(negedge clk);
    cfg_index <= REG_ORIGIN_LON;
    cfg_data <= lon[31:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic longint any_lat();
    int pick;
    pick = $urandom % 10;
    if (pick == 0) return longint'(signed'(31'($urandom)));
    if (pick == 1)
      return ($urandom % 2) ? DEG90 - $urandom_range(0, 3) : -DEG90 + $urandom_range(0, 3);
    return longint'($urandom_range(0, 1509949440)) - DEG90;
  endfunction

  function automatic longint any_lon();
    int pick;
    pick = $urandom % 10;
    if (pick == 0) return longint'(signed'($urandom));
    if (pick == 1)
      return ($urandom % 2) ? DEG180 - $urandom_range(0, 3) : -DEG180 + $urandom_range(0, 3);
    return longint'($urandom_range(0, 32'd3019898880)) - DEG180;
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_mode = 0;
    set_origin(0, 0);
    send_point(0, 0);
    send_point(DEG90, 0);
    send_point(-DEG90, 0);
    send_point(0, DEG180);
    send_point(0, -DEG180);
    send_point(DEG90, DEG180);
    send_point(-DEG90, -DEG180);
    send_point(0, DEG90);
    send_point(DEG90 / 2, DEG90 / 2);
    send_point(1, 1);
    send_point(-1, -1);
    send_point(-(64'sd1 << 30), -(64'sd1 << 31));
    send_point((64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
    send_point(DEG90 + 8388608, DEG90);
    send_point(-DEG90 - 8388608, -DEG90);
    set_origin(-DEG90, -DEG180);
    send_point(DEG90, DEG180);
    send_point(DEG90, -DEG180);
    send_point(-DEG90, DEG180 - 1);
    send_point(0, 0);
    set_origin(DEG90, DEG180);
    send_point(-DEG90, -DEG180);
    send_point(DEG90, 0);
    send_point(0, -1);

    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        0: set_origin(0, 0);
        1: set_origin(DEG90, DEG180);
        2: set_origin(-DEG90, -DEG180);
        3: set_origin(64'sd377487360, -64'sd1006632960);
        default: set_origin(longint'($urandom_range(0, 1509949440)) - DEG90,
                            longint'($urandom_range(0, 32'd3019898880)) - DEG180);
      endcase
      for (int k = 0; k < 255; k++) send_point(any_lat(), any_lon());
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("sent %0d points over six origin settings and four idle patterns,", sent);
    $display("%0d offsets checked, %0d errors", checked, errors);
    if (errors == 0) begin
      $display("latlon_to_local_meters: match");
    end else begin
      $display("latlon_to_local_meters: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ll2m_pkg.sv
hw/rtl/ll2m_rot.sv
hw/rtl/ll2m_vec.sv
hw/rtl/ll2m_sqrt.sv
hw/rtl/latlon_to_local_meters.sv
verif/ll2m_checker.sv
verif/tb_latlon_to_local_meters.sv
